/* rtl/core/nll_pkg.sv */
`timescale 1ns / 1ps

package nll_pkg;

  // Counter widths
  localparam int POS_W = 16;
  localparam int LEN_W = 16;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam int NUM_KW = 9;
  localparam int KW_MAX_LEN = 9;
  localparam int KW_IDX_W = $clog2(KW_MAX_LEN);

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_STRING = 3'd3,
    MODE_DASH   = 3'd4
  } mode_t;

  // Token kinds
  localparam logic [4:0] TK_IDENT    = 5'd0;
  localparam logic [4:0] TK_NUMBER   = 5'd1;
  localparam logic [4:0] TK_STRING   = 5'd2;
  localparam logic [4:0] TK_COLON    = 5'd3;
  localparam logic [4:0] TK_ARROW    = 5'd4;
  localparam logic [4:0] TK_EQUALS   = 5'd5;
  localparam logic [4:0] TK_COMMA    = 5'd6;
  localparam logic [4:0] TK_LPAREN   = 5'd7;
  localparam logic [4:0] TK_RPAREN   = 5'd8;
  localparam logic [4:0] TK_UNKNOWN  = 5'd9;
  localparam logic [4:0] TK_EOF      = 5'd10;
  localparam logic [4:0] TK_KEYWORD0 = 5'd11;

  // Input kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  // Characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // Keywords, right-justified in a fixed-width string
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KW] = '{
    "component", "circuit", "module", "test", "connect",
    "bus", "stimulus", "assert", "wait"
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd9, 4'd7, 4'd6, 4'd4, 4'd7, 4'd3, 4'd8, 4'd6, 4'd4
  };

  // Character idx of keyword k; zero past its end
  function automatic logic [7:0] kw_char(input int k, input logic [KW_IDX_W-1:0] idx);
    logic [7:0] ch;
    int pos;
    ch = 8'h00;
    pos = int'(KW_LEN[k]) - 1 - int'(idx);
    if (pos >= 0) begin
      ch = KW_TEXT[k][pos*8 +: 8];
    end
    return ch;
  endfunction

  typedef struct packed {
    logic [4:0]       kind;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
    logic [LEN_W-1:0] length;
    logic [7:0]       vchar;
  } tok_t;

  // Tokens produced by one input word
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok1;
    tok_t       tok0;
  } scan_out_t;

endpackage

/* rtl/core/nll_scan.sv */
`timescale 1ns / 1ps

module nll_scan
  import nll_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic      kind,
  input  logic [7:0] char_code,
  output scan_out_t result
);

  mode_t             mode, mode_next;
  logic [7:0]        quote, quote_next;
  logic [NUM_KW-1:0] alive, alive_next;
  logic [LEN_W-1:0]  wlen, wlen_next;
  logic [POS_W-1:0]  line, line_next;
  logic [POS_W-1:0]  column, column_next;

  logic             is_eof;
  logic             c_alpha, c_digit, c_ident, c_quote;
  logic [LEN_W-1:0] wlen_inc;
  logic [POS_W-1:0] adv_line, adv_column;
  logic [4:0]       pend_kind;
  logic [NUM_KW-1:0] match_cont, match_first;

  // Outcome of lexing the character from the idle state
  mode_t            idle_mode;
  logic             idle_emit;
  logic [4:0]       idle_kind;
  logic [LEN_W-1:0] idle_wlen;

  // Character classes and counters
  always_comb begin
    is_eof   = (kind == KIND_EOF);
    c_alpha  = (char_code >= "a" && char_code <= "z") || (char_code >= "A" && char_code <= "Z");
    c_digit  = (char_code >= "0" && char_code <= "9");
    c_ident  = c_alpha || c_digit || (char_code == CH_UNDER);
    c_quote  = (char_code == CH_DQUOTE) || (char_code == CH_SQUOTE);
    wlen_inc = (wlen == LEN_MAX) ? wlen : wlen + 1'b1;
    if (char_code == CH_NL) begin
      adv_line   = (line == POS_MAX) ? line : line + 1'b1;
      adv_column = POS_W'(1);
    end else begin
      adv_line   = line;
      adv_column = (column == POS_MAX) ? column : column + 1'b1;
    end
  end

  // Keyword candidate masks and pending identifier kind
  always_comb begin
    pend_kind = TK_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      match_cont[k]  = alive[k] && (wlen < LEN_W'(KW_LEN[k])) &&
                       (kw_char(k, wlen[KW_IDX_W-1:0]) == char_code);
      match_first[k] = (kw_char(k, '0) == char_code);
    end
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (alive[k] && wlen == LEN_W'(KW_LEN[k])) begin
        pend_kind = TK_KEYWORD0 + 5'(k);
      end
    end
    if (mode == MODE_NUMBER) begin
      pend_kind = TK_NUMBER;
    end
  end

  // Idle-state lexing of the current character
  always_comb begin
    idle_mode = MODE_IDLE;
    idle_emit = 1'b0;
    idle_kind = TK_UNKNOWN;
    idle_wlen = '0;
    priority if (char_code == CH_SPACE || char_code == CH_TAB) begin
      idle_emit = 1'b0;
    end else if (char_code == CH_COLON) begin
      idle_emit = 1'b1;
      idle_kind = TK_COLON;
    end else if (char_code == CH_EQUALS) begin
      idle_emit = 1'b1;
      idle_kind = TK_EQUALS;
    end else if (char_code == CH_COMMA) begin
      idle_emit = 1'b1;
      idle_kind = TK_COMMA;
    end else if (char_code == CH_LPAREN) begin
      idle_emit = 1'b1;
      idle_kind = TK_LPAREN;
    end else if (char_code == CH_RPAREN) begin
      idle_emit = 1'b1;
      idle_kind = TK_RPAREN;
    end else if (char_code == CH_DASH) begin
      idle_mode = MODE_DASH;
    end else if (c_quote) begin
      idle_mode = MODE_STRING;
    end else if (c_alpha || char_code == CH_UNDER) begin
      idle_mode = MODE_IDENT;
      idle_wlen = LEN_W'(1);
    end else if (c_digit) begin
      idle_mode = MODE_NUMBER;
      idle_wlen = LEN_W'(1);
    end else begin
      idle_emit = 1'b1;
    end
  end

  // Next state
  always_comb begin
    mode_next   = mode;
    quote_next  = quote;
    alive_next  = alive;
    wlen_next   = wlen;
    line_next   = line;
    column_next = column;
    if (is_eof) begin
      mode_next  = MODE_IDLE;
      quote_next = '0;
      wlen_next  = '0;
    end else begin
      line_next   = adv_line;
      column_next = adv_column;
      unique case (mode)
        MODE_IDENT: begin
          if (c_ident) begin
            alive_next = match_cont;
            wlen_next  = wlen_inc;
          end else begin
            mode_next = idle_mode;
            wlen_next = idle_wlen;
          end
        end
        MODE_NUMBER: begin
          if (c_digit) begin
            wlen_next = wlen_inc;
          end else begin
            mode_next = idle_mode;
            wlen_next = idle_wlen;
          end
        end
        MODE_STRING: begin
          if (char_code == quote || char_code == CH_NL) begin
            mode_next  = MODE_IDLE;
            quote_next = '0;
            wlen_next  = '0;
          end else begin
            wlen_next = wlen_inc;
          end
        end
        MODE_DASH: begin
          if (char_code == CH_DASH) begin
            mode_next = MODE_IDLE;
          end else begin
            mode_next = idle_mode;
            wlen_next = idle_wlen;
          end
        end
        default: begin
          mode_next = idle_mode;
          wlen_next = idle_wlen;
        end
      endcase
      // Entering a token from the idle path
      if (mode_next == MODE_IDENT && mode != MODE_IDENT) begin
        alive_next = match_first;
      end
      if (mode_next == MODE_STRING && mode != MODE_STRING) begin
        quote_next = char_code;
      end
    end
  end

  // Tokens caused by this word
  always_comb begin
    tok_t first, second;
    logic has_first, has_second;
    first      = '{kind: TK_UNKNOWN, line: line, column: column, length: '0, vchar: 8'h00};
    second     = '{kind: TK_EOF, line: line, column: column, length: '0, vchar: 8'h00};
    has_first  = 1'b0;
    has_second = 1'b0;
    if (is_eof) begin
      has_second = 1'b1;
      unique case (mode)
        MODE_IDENT, MODE_NUMBER: begin
          has_first    = 1'b1;
          first.kind   = pend_kind;
          first.length = wlen;
        end
        MODE_STRING: has_first = 1'b1;
        MODE_DASH: begin
          has_first   = 1'b1;
          first.vchar = CH_DASH;
        end
        default: has_first = 1'b0;
      endcase
    end else begin
      // Single-character token from the idle path, at the advanced position
      second = '{kind: idle_kind, line: adv_line, column: adv_column, length: '0,
                 vchar: char_code};
      unique case (mode)
        MODE_IDENT, MODE_NUMBER: begin
          if (!((mode == MODE_IDENT && c_ident) || (mode == MODE_NUMBER && c_digit))) begin
            has_first    = 1'b1;
            first.kind   = pend_kind;
            first.length = wlen;
            has_second   = idle_emit;
          end
        end
        MODE_STRING: begin
          if (char_code == quote || char_code == CH_NL) begin
            has_first = 1'b1;
            first     = '{kind: TK_STRING, line: adv_line, column: adv_column,
                          length: wlen, vchar: 8'h00};
          end
        end
        MODE_DASH: begin
          has_first = 1'b1;
          if (char_code == CH_DASH) begin
            first = '{kind: TK_ARROW, line: adv_line, column: adv_column,
                      length: '0, vchar: 8'h00};
          end else begin
            first.vchar = CH_DASH;
            has_second  = idle_emit;
          end
        end
        default: has_second = idle_emit;
      endcase
    end
    // Pack so that tok0 always holds the earliest token
    result.count = {1'b0, has_first} + {1'b0, has_second};
    result.tok0  = has_first ? first : second;
    result.tok1  = second;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      quote  <= '0;
      alive  <= '1;
      wlen   <= '0;
      line   <= POS_W'(1);
      column <= POS_W'(1);
    end else if (accept) begin
      mode   <= mode_next;
      quote  <= quote_next;
      alive  <= alive_next;
      wlen   <= wlen_next;
      line   <= line_next;
      column <= column_next;
    end
  end

  // Line and column never fall below one
  assert property (@(posedge clk) disable iff (rst) line != '0 && column != '0)
    else $error("position counter reached zero");

  // A string is never open without its opening quote
  assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_STRING) |-> (quote == CH_DQUOTE || quote == CH_SQUOTE))
    else $error("open string without quote");

  // End of input always leaves the scanner idle
  assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_EOF) |=> (mode == MODE_IDLE && wlen == '0))
    else $error("scanner not idle after end of input");

endmodule

/* rtl/core/netlist_language_lexer.sv */
`timescale 1ns / 1ps
// A token is written into the registered token queue when the word that causes it is accepted.
// Throughput: one input word per cycle while each word yields at most one token and the
//   output keeps up; a word yielding two tokens sends them in turn over the one-word port.
// The four-entry token queue takes a word whenever it holds two tokens or fewer.
// Reset: synchronous, clears the queue and sets line and column to one, scanner idle.

module netlist_language_lexer
  import nll_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             kind,
  input  logic [7:0]       char_code,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [4:0]       token_kind,
  output logic [POS_W-1:0] token_line,
  output logic [POS_W-1:0] token_column,
  output logic [LEN_W-1:0] value_length,
  output logic [7:0]       value_char,
  output logic             is_last
);

  scan_out_t scan;
  logic      accept, pop;

  tok_t              q_tok  [QDEPTH];
  logic              q_last [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  logic [1:0]        push_n;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;

  nll_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .char_code (char_code),
    .result    (scan)
  );

  // Queue occupancy
  always_comb begin
    push_n     = accept ? scan.count : 2'd0;
    count_next = count + QCNT_W'(push_n) - QCNT_W'(pop);
  end

  assign in_ready  = (count <= QCNT_W'(QDEPTH - 2));
  assign out_valid = (count != '0);

  // Token storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_tok[wr_ptr]  <= scan.tok0;
      q_last[wr_ptr] <= (push_n == 2'd1);
    end
    if (push_n == 2'd2) begin
      q_tok[wr_ptr + 1'b1]  <= scan.tok1;
      q_last[wr_ptr + 1'b1] <= 1'b1;
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

  // Output word from the queue head
  always_comb begin
    token_kind   = q_tok[rd_ptr].kind;
    token_line   = q_tok[rd_ptr].line;
    token_column = q_tok[rd_ptr].column;
    value_length = q_tok[rd_ptr].length;
    value_char   = q_tok[rd_ptr].vchar;
    is_last      = q_last[rd_ptr];
  end

  // Queue never overflows
  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QDEPTH))
    else $error("token queue overflow");

  // End of input always produces at least the eof token
  assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_EOF) |=> out_valid)
    else $error("no token after end of input");

  // Draining the last token with nothing new leaves the queue empty
  assert property (@(posedge clk) disable iff (rst)
    (pop && count == QCNT_W'(1) && !accept) |=> !out_valid)
    else $error("stale token after drain");

endmodule

/* sim/netlist_language_lexer_tb.sv */
`timescale 1ns / 1ps

module netlist_language_lexer_tb;
  import nll_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             kind = KIND_CHAR;
  logic [7:0]       char_code = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [4:0]       token_kind;
  logic [POS_W-1:0] token_line;
  logic [POS_W-1:0] token_column;
  logic [LEN_W-1:0] value_length;
  logic [7:0]       value_char;
  logic             is_last;

  netlist_language_lexer DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .char_code(char_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .token_kind(token_kind),
    .token_line(token_line),
    .token_column(token_column),
    .value_length(value_length),
    .value_char(value_char),
    .is_last(is_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  typedef struct {
    logic [4:0]       kind;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
    logic [LEN_W-1:0] length;
    logic [7:0]       vchar;
    logic             last;
  } token_t;

  string keyword_names [NUM_KW] = '{
    "component", "circuit", "module", "test", "connect",
    "bus", "stimulus", "assert", "wait"
  };

  token_t expected_tokens [$];
  int     mismatches = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_left = 0;
  int     words_sent = 0;

  // Lexer shadow state
  mode_t            scan_st = MODE_IDLE;
  logic [7:0]       open_quote = 8'h00;
  logic [NUM_KW-1:0] kw_alive = '1;
  logic [LEN_W-1:0] run_len = '0;
  logic [POS_W-1:0] cur_line = POS_W'(1);
  logic [POS_W-1:0] cur_col = POS_W'(1);

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void bump_position(logic [7:0] c);
    if (c == CH_NL) begin
      if (cur_line != POS_MAX) cur_line++;
      cur_col = POS_W'(1);
    end else if (cur_col != POS_MAX) begin
      cur_col++;
    end
  endfunction

  function automatic void bump_length();
    if (run_len != LEN_MAX) run_len++;
  endfunction

  function automatic void push_token(logic [4:0] k, logic [7:0] v, logic [LEN_W-1:0] len);
    token_t t;
    t = '{k, cur_line, cur_col, len, v, 1'b0};
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  // Narrow the keyword candidates by one identifier character
  function automatic void ident_char_step(logic [7:0] c);
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_alive[k]) begin
        if (!(run_len < keyword_names[k].len() && keyword_names[k][run_len] == c))
          kw_alive[k] = 1'b0;
      end
    end
    bump_length();
    bump_position(c);
  endfunction

  function automatic logic [4:0] ident_kind();
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_alive[k] && run_len == keyword_names[k].len())
        return TK_KEYWORD0 + 5'(k);
    end
    return TK_IDENT;
  endfunction

  // Character seen between tokens
  function automatic void lex_idle_char(logic [7:0] c);
    logic [4:0] single;
    single = TK_UNKNOWN;
    if (c == CH_SPACE || c == CH_TAB) begin
      bump_position(c);
      return;
    end
    if (c == CH_DASH) begin
      bump_position(c);
      scan_st = MODE_DASH;
      return;
    end
    if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      bump_position(c);
      open_quote = c;
      run_len = '0;
      scan_st = MODE_STRING;
      return;
    end
    if (is_letter(c) || c == CH_UNDER) begin
      scan_st = MODE_IDENT;
      kw_alive = '1;
      run_len = '0;
      ident_char_step(c);
      return;
    end
    if (is_digit(c)) begin
      scan_st = MODE_NUMBER;
      run_len = LEN_W'(1);
      bump_position(c);
      return;
    end
    case (c)
      CH_COLON:  single = TK_COLON;
      CH_EQUALS: single = TK_EQUALS;
      CH_COMMA:  single = TK_COMMA;
      CH_LPAREN: single = TK_LPAREN;
      CH_RPAREN: single = TK_RPAREN;
      default:   single = TK_UNKNOWN;
    endcase
    bump_position(c);
    push_token(single, c, '0);
  endfunction

  // Expected tokens for one accepted word
  function automatic void predict_word(logic k, logic [7:0] c);
    int first;
    first = expected_tokens.size();
    if (k == KIND_EOF) begin
      case (scan_st)
        MODE_IDENT:  push_token(ident_kind(), 8'h00, run_len);
        MODE_NUMBER: push_token(TK_NUMBER, 8'h00, run_len);
        MODE_STRING: push_token(TK_UNKNOWN, 8'h00, '0);
        MODE_DASH:   push_token(TK_UNKNOWN, CH_DASH, '0);
        default: ;
      endcase
      push_token(TK_EOF, 8'h00, '0);
      scan_st = MODE_IDLE;
      open_quote = 8'h00;
      run_len = '0;
    end else begin
      case (scan_st)
        MODE_IDENT: begin
          if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
            ident_char_step(c);
          end else begin
            push_token(ident_kind(), 8'h00, run_len);
            scan_st = MODE_IDLE;
            run_len = '0;
            lex_idle_char(c);
          end
        end
        MODE_NUMBER: begin
          if (is_digit(c)) begin
            bump_length();
            bump_position(c);
          end else begin
            push_token(TK_NUMBER, 8'h00, run_len);
            scan_st = MODE_IDLE;
            run_len = '0;
            lex_idle_char(c);
          end
        end
        MODE_STRING: begin
          // closing quote or newline ends the string
          if (c == open_quote || c == CH_NL) begin
            bump_position(c);
            push_token(TK_STRING, 8'h00, run_len);
            scan_st = MODE_IDLE;
            open_quote = 8'h00;
            run_len = '0;
          end else begin
            bump_length();
            bump_position(c);
          end
        end
        MODE_DASH: begin
          scan_st = MODE_IDLE;
          if (c == CH_DASH) begin
            bump_position(c);
            push_token(TK_ARROW, 8'h00, '0);
          end else begin
            push_token(TK_UNKNOWN, CH_DASH, '0);
            lex_idle_char(c);
          end
        end
        default: begin
          scan_st = MODE_IDLE;
          lex_idle_char(c);
        end
      endcase
    end
    if (expected_tokens.size() > first)
      expected_tokens[expected_tokens.size()-1].last = 1'b1;
  endfunction

  // Output side: ready pattern, long hold-off when requested
  always @(posedge clk) begin
    if (rst || hold_left > 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Token checker
  always @(posedge clk) begin : check_token
    token_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected token kind=%0d line=%0d col=%0d len=%0d char=%0h last=%0b",
                 $time, token_kind, token_line, token_column, value_length,
                 value_char, is_last);
      end else begin
        want = expected_tokens.pop_front();
        if (want.kind !== token_kind || want.line !== token_line ||
            want.column !== token_column || want.length !== value_length ||
            want.vchar !== value_char || want.last !== is_last) begin
          mismatches++;
          $display("%0t: expected kind=%0d line=%0d col=%0d len=%0d char=%0h last=%0b,",
                   $time, want.kind, want.line, want.column, want.length, want.vchar,
                   want.last,
                   " got kind=%0d line=%0d col=%0d len=%0d char=%0h last=%0b",
                   token_kind, token_line, token_column, value_length,
                   value_char, is_last);
        end
      end
    end
  end

  // Offer one word, with random idle cycles ahead of it
  task automatic send_word(input logic k, input logic [7:0] c);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    kind <= k;
    char_code <= c;
    do @(posedge clk); while (!in_ready);
    predict_word(k, c);
    if (!(k == KIND_CHAR && (c == CH_SPACE || c == CH_TAB))) words_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_word(KIND_CHAR, s[i]);
  endtask

  // Sender pauses until every token has come out
  task automatic drain_tokens();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_ident_char(bit first);
    int r;
    r = $urandom_range(first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'("0" + r - 53);
  endfunction

  // One random lexical fragment, mostly well formed
  task automatic send_random_chunk();
    int pick;
    int n;
    int k;
    logic [7:0] q;
    logic [7:0] b;
    string text;
    pick = $urandom_range(99);
    if (pick < 20) begin
      k = $urandom_range(NUM_KW - 1);
      text = keyword_names[k];
      n = $urandom_range(99);
      if (n >= 60 && n < 80) text = text.substr(0, $urandom_range(text.len() - 1));
      send_text(text);
      if (n >= 80) send_word(KIND_CHAR, rand_ident_char(1'b0));
    end else if (pick < 35) begin
      send_word(KIND_CHAR, rand_ident_char(1'b1));
      repeat ($urandom_range(11)) send_word(KIND_CHAR, rand_ident_char(1'b0));
    end else if (pick < 45) begin
      repeat ($urandom_range(6, 1)) send_word(KIND_CHAR, 8'("0" + $urandom_range(9)));
    end else if (pick < 55) begin
      q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
      send_word(KIND_CHAR, q);
      repeat ($urandom_range(8)) begin
        do b = 8'($urandom_range(255)); while (b == q || b == CH_NL);
        send_word(KIND_CHAR, b);
      end
      n = $urandom_range(9);
      if (n < 8) send_word(KIND_CHAR, q);
      else if (n == 8) send_word(KIND_CHAR, CH_NL);
      else send_word(KIND_EOF, 8'($urandom_range(255)));
    end else if (pick < 70) begin
      case ($urandom_range(7))
        0: send_word(KIND_CHAR, CH_COLON);
        1: send_word(KIND_CHAR, CH_EQUALS);
        2: send_word(KIND_CHAR, CH_COMMA);
        3: send_word(KIND_CHAR, CH_LPAREN);
        4: send_word(KIND_CHAR, CH_RPAREN);
        5: send_text("--");
        6: send_text("---");
        default: send_word(KIND_CHAR, CH_DASH);
      endcase
    end else if (pick < 80) begin
      case ($urandom_range(2))
        0: send_word(KIND_CHAR, CH_SPACE);
        1: send_word(KIND_CHAR, CH_TAB);
        default: send_word(KIND_CHAR, CH_NL);
      endcase
    end else if (pick < 95) begin
      send_word(KIND_CHAR, 8'($urandom_range(255)));
    end else begin
      send_word(KIND_EOF, 8'($urandom_range(255)));
    end
  endtask

  // Keyword, arrow and dash handling, all punctuation, both quotes,
  // string ended by newline, high bytes, open string and idle at end of input
  task automatic test_directed();
    send_idle_pct = 10;
    recv_idle_pct = 60;
    send_text("wait ---x:=,()\t9\"");
    send_word(KIND_CHAR, 8'hFF);
    send_word(KIND_CHAR, CH_NL);
    send_word(KIND_CHAR, 8'h80);
    send_text("'_'\"");
    send_word(KIND_EOF, 8'h00);
    send_word(KIND_EOF, 8'hFF);
    drain_tokens();
  endtask

  task automatic test_random_phase(input int count, input int sp, input int rp);
    int start;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    start = words_sent;
    while (words_sent - start < count) send_random_chunk();
    drain_tokens();
  endtask

  // Output stalled for a long stretch while words keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left <= 400;
    repeat (60) send_word(KIND_CHAR, CH_COMMA);
    repeat (20) send_random_chunk();
    drain_tokens();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(160, 10, 60);
    test_random_phase(160, 60, 10);
    test_random_phase(160, 0, 0);
    test_backpressure();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
